[rtl/fha_pkg.sv]
`default_nettype none
package fha_pkg;

	localparam int NBLK      = 64;
	localparam int HDR       = 32;
	localparam int MIN_SPLIT = 16;
	localparam int MAX_PAGES = 16;
	localparam int PAGE_SH   = 12;
	localparam int DELAY     = 2;
	localparam int PASS_LEN  = NBLK + DELAY;
	localparam int CNT_W     = $clog2(NBLK + 1);
	localparam int PC_W      = $clog2(PASS_LEN);

	// Operation codes of the func field.
	typedef enum logic [1:0] {
		FN_ALLOC  = 2'd0,
		FN_FREE   = 2'd1,
		FN_FORMAT = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	// Result status codes.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_ZERO   = 3'd1;
	localparam logic [2:0] ST_NOFIT  = 3'd2;
	localparam logic [2:0] ST_BADPTR = 3'd3;
	localparam logic [2:0] ST_NULL   = 3'd4;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_RUN,
		CS_DONE
	} ctl_state_t;

	// One block table entry: header offset, data size, free mark.
	typedef struct packed {
		logic [15:0] ofs;
		logic [15:0] size;
		logic        free;
	} blk_t;

	// Command from the controller that starts one walk over the table.
	typedef struct packed {
		logic             start;
		logic             is_free;
		logic [16:0]      size_req;
		logic [15:0]      ptr;
		logic [CNT_W-1:0] count;
	} walk_cmd_t;

	// Outcome of a walk; all fields but done are held until the next one starts.
	typedef struct packed {
		logic             done;
		logic             found;
		logic             bad;
		logic [15:0]      ptr;
		logic [CNT_W-1:0] count;
		logic [16:0]      delta;
	} walk_res_t;

endpackage
`default_nettype wire

[rtl/fha_cell.sv]
`default_nettype none
module fha_cell (
	input  wire                logic clk,
	input  wire                logic shift,
	input  wire                logic ld,
	input  fha_pkg::blk_t      ld_data,
	input  fha_pkg::blk_t      nxt,
	output fha_pkg::blk_t      ent
);
	import fha_pkg::*;

	blk_t ent_q;

	// The entry moves one place toward the head on every shift.
	always_ff @(posedge clk) begin
		if (ld) begin
			ent_q <= ld_data;
		end else if (shift) begin
			ent_q <= nxt;
		end
	end

	assign ent = ent_q;

endmodule
`default_nettype wire

[rtl/fha_walk.sv]
`default_nettype none
module fha_walk (
	input  wire               logic clk,
	input  wire               logic arst_n,
	input  fha_pkg::walk_cmd_t cmd,
	input  fha_pkg::blk_t     head,
	output logic              shift,
	output fha_pkg::blk_t     push,
	output fha_pkg::walk_res_t res
);
	import fha_pkg::*;

	logic             run_q;
	logic [PC_W-1:0]  c_q;
	logic             is_free_q;
	logic [16:0]      s_q;
	logic [15:0]      p_q;
	logic [CNT_W-1:0] cnt_in_q;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q;
	logic             bad_q;
	logic             mrg_q;
	logic             done_q;
	logic [15:0]      ptr_q;
	logic [16:0]      delta_q;
	blk_t             f_q [3];
	logic [1:0]       n_q;

	blk_t             lst [4];
	logic [2:0]       nl;
	logic             ev;
	logic             found_d;
	logic             bad_d;
	logic             mrg_d;
	logic [15:0]      ptr_d;
	logic [16:0]      delta_d;
	logic [CNT_W-1:0] cnt_d;
	logic             pop;
	blk_t             f_d [3];
	logic [1:0]       n_d;
	logic [1:0]       li;

	// Edit the stream: the small queue delays entries so that a merge can
	// still change the entry before it and a split can insert one more.
	always_comb begin
		lst[0]  = f_q[0];
		lst[1]  = f_q[1];
		lst[2]  = f_q[2];
		lst[3]  = head;
		nl      = {1'b0, n_q};
		ev      = run_q && ({1'b0, c_q} < {{(PC_W + 1 - CNT_W){1'b0}}, cnt_in_q});
		found_d = found_q;
		bad_d   = bad_q;
		mrg_d   = 1'b0;
		ptr_d   = ptr_q;
		delta_d = delta_q;
		cnt_d   = cnt_q;
		li      = 2'(nl - 3'd1);
		if (ev) begin
			if (!is_free_q) begin
				if (!found_q && head.free && {1'b0, head.size} >= s_q) begin
					found_d = 1'b1;
					ptr_d   = head.ofs + 16'(HDR);
					if ({2'b00, head.size} >= {1'b0, s_q} + 18'(HDR + MIN_SPLIT) &&
						cnt_q < CNT_W'(NBLK)) begin
						lst[nl[1:0]]        = '{ofs: head.ofs, size: s_q[15:0], free: 1'b0};
						lst[2'(nl + 3'd1)] = '{ofs: head.ofs + 16'(HDR) + s_q[15:0],
							size: head.size - s_q[15:0] - 16'(HDR), free: 1'b1};
						nl      = nl + 3'd2;
						cnt_d   = cnt_q + CNT_W'(1);
						delta_d = s_q + 17'(HDR);
					end else begin
						lst[nl[1:0]] = '{ofs: head.ofs, size: head.size, free: 1'b0};
						nl           = nl + 3'd1;
						delta_d      = {1'b0, head.size} + 17'(HDR);
					end
				end else begin
					lst[nl[1:0]] = head;
					nl           = nl + 3'd1;
				end
			end else begin
				if (mrg_q && head.free) begin
					// Free block right after the one just released joins it.
					lst[li].size = lst[li].size + 16'(HDR) + head.size;
					cnt_d        = cnt_q - CNT_W'(1);
				end else if (!found_q && {1'b0, head.ofs} + 17'(HDR) == {1'b0, p_q}) begin
					found_d = 1'b1;
					if (head.free) begin
						bad_d        = 1'b1;
						lst[nl[1:0]] = head;
						nl           = nl + 3'd1;
					end else begin
						delta_d = {1'b0, head.size} + 17'(HDR);
						mrg_d   = 1'b1;
						if (nl != 3'd0 && lst[li].free) begin
							lst[li].size = lst[li].size + 16'(HDR) + head.size;
							cnt_d        = cnt_q - CNT_W'(1);
						end else begin
							lst[nl[1:0]] = '{ofs: head.ofs, size: head.size, free: 1'b1};
							nl           = nl + 3'd1;
						end
					end
				end else begin
					lst[nl[1:0]] = head;
					nl           = nl + 3'd1;
				end
			end
		end
		pop = c_q >= PC_W'(DELAY);
		if (pop) begin
			f_d[0] = lst[1];
			f_d[1] = lst[2];
			f_d[2] = lst[3];
			n_d    = (nl == 3'd0) ? 2'd0 : 2'(nl - 3'd1);
		end else begin
			f_d[0] = lst[0];
			f_d[1] = lst[1];
			f_d[2] = lst[2];
			n_d    = nl[1:0];
		end
	end

	// Control of the walk: one table position per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			c_q     <= '0;
			n_q     <= '0;
			found_q <= 1'b0;
			bad_q   <= 1'b0;
			mrg_q   <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			delta_q <= '0;
			ptr_q   <= '0;
		end else if (cmd.start) begin
			run_q   <= 1'b1;
			c_q     <= '0;
			n_q     <= '0;
			found_q <= 1'b0;
			bad_q   <= 1'b0;
			mrg_q   <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= cmd.count;
			delta_q <= '0;
			ptr_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (run_q) begin
				n_q     <= n_d;
				found_q <= found_d;
				bad_q   <= bad_d;
				mrg_q   <= mrg_d;
				cnt_q   <= cnt_d;
				delta_q <= delta_d;
				ptr_q   <= ptr_d;
				if (c_q == PC_W'(PASS_LEN - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					c_q <= c_q + PC_W'(1);
				end
			end
		end
	end

	// Queue contents and the command fields are payload.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			is_free_q <= cmd.is_free;
			s_q       <= cmd.size_req;
			p_q       <= cmd.ptr;
			cnt_in_q  <= cmd.count;
		end else if (run_q) begin
			f_q[0] <= f_d[0];
			f_q[1] <= f_d[1];
			f_q[2] <= f_d[2];
		end
	end

	assign shift     = run_q;
	assign push      = lst[0];
	assign res.done  = done_q;
	assign res.found = found_q;
	assign res.bad   = bad_q;
	assign res.ptr   = ptr_q;
	assign res.count = cnt_q;
	assign res.delta = delta_q;

endmodule
`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
`default_nettype none
// First-fit heap allocator over a region of up to 16 pages of 4096 bytes, with a
// 64-entry address-ordered block table held in a ring of cells. Format, a zero-size
// allocate, a null free and the unused function code finish without a table walk.
// Allocate and free rotate the whole table once past the edit unit at its head,
// one entry per cycle; the controller then sees the walk end, loads the output
// register and returns to idle once the previous result has been taken.
// One transaction is worked on at a time, and a new one is accepted while the
// previous result still waits in the output register.
module first_fit_heap_allocator (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        psel,
	input  wire  logic        penable,
	input  wire  logic        pwrite,
	input  wire  logic [2:0]  paddr,
	input  wire  logic [31:0] pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire  logic        in_valid,
	output logic              in_ready,
	input  wire  logic [1:0]  func,
	input  wire  logic [15:0] req_size,
	input  wire  logic [15:0] ptr_in,
	output logic              out_valid,
	input  wire  logic        out_ready,
	output logic [15:0]       ptr_out,
	output logic [2:0]        status,
	output logic [16:0]       used_bytes,
	output logic [16:0]       total_bytes
);
	import fha_pkg::*;

	ctl_state_t       state_q;
	ctl_state_t       state_d;
	logic [4:0]       pages_q;
	logic [CNT_W-1:0] count_q;
	logic [16:0]      used_q;
	logic [16:0]      total_q;
	func_t            op_q;
	logic [15:0]      req_q;
	logic [15:0]      pin_q;
	logic             out_valid_q;
	logic [15:0]      ptr_out_q;
	logic [2:0]       status_q;
	logic [16:0]      used_out_q;
	logic [16:0]      total_out_q;

	logic             accept;
	logic             need_walk;
	logic             finish;
	walk_cmd_t        cmd;
	walk_res_t        res;
	logic             shift;
	blk_t             push;
	blk_t             ent [NBLK];
	blk_t             fmt_blk;
	logic [4:0]       pages_eff;
	logic [16:0]      fmt_total;
	logic [16:0]      size_rnd;
	logic [15:0]      r_ptr;
	logic [2:0]       r_status;
	logic [16:0]      r_used;
	logic [16:0]      r_total;
	logic [CNT_W-1:0] r_count;
	logic             do_format;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= 5'd16;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			pages_q <= pwdata[4:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {27'd0, pages_q};

	assign accept    = in_valid && in_ready;
	assign size_rnd  = ({1'b0, req_size} + 17'd7) & ~17'd7;
	assign need_walk = (func_t'(func) == FN_ALLOC && req_size != 16'd0) ||
		(func_t'(func) == FN_FREE && ptr_in != 16'd0);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (accept) begin
					state_d = need_walk ? CS_RUN : CS_DONE;
				end
			end
			CS_RUN: begin
				if (res.done) begin
					state_d = CS_DONE;
				end
			end
			CS_DONE: begin
				if (finish) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		in_ready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			CS_IDLE: in_ready = 1'b1;
			CS_RUN:  ;
			CS_DONE: finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk command.
	assign cmd.start    = accept && need_walk;
	assign cmd.is_free  = func_t'(func) == FN_FREE;
	assign cmd.size_req = size_rnd;
	assign cmd.ptr      = ptr_in;
	assign cmd.count    = count_q;

	fha_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (ent[0]),
		.shift  (shift),
		.push   (push),
		.res    (res)
	);

	// Format block that spans the clamped page count.
	always_comb begin
		if (pages_q == 5'd0) begin
			pages_eff = 5'd1;
		end else if (pages_q > 5'(MAX_PAGES)) begin
			pages_eff = 5'(MAX_PAGES);
		end else begin
			pages_eff = pages_q;
		end
	end
	assign fmt_total    = {pages_eff, 12'd0};
	assign fmt_blk.ofs  = 16'd0;
	assign fmt_blk.size = 16'(fmt_total - 17'(HDR));
	assign fmt_blk.free = 1'b1;
	assign do_format    = finish && op_q == FN_FORMAT;

	// Ring of table cells; the edit unit refills the tail.
	for (genvar gi = 0; gi < NBLK; gi++) begin : g_cell
		if (gi == 0) begin : g_head
			fha_cell u_cell (
				.clk     (clk),
				.shift   (shift),
				.ld      (do_format),
				.ld_data (fmt_blk),
				.nxt     (ent[1]),
				.ent     (ent[0])
			);
		end else if (gi == NBLK - 1) begin : g_tail
			fha_cell u_cell (
				.clk     (clk),
				.shift   (shift),
				.ld      (1'b0),
				.ld_data (fmt_blk),
				.nxt     (push),
				.ent     (ent[gi])
			);
		end else begin : g_mid
			fha_cell u_cell (
				.clk     (clk),
				.shift   (shift),
				.ld      (1'b0),
				.ld_data (fmt_blk),
				.nxt     (ent[gi+1]),
				.ent     (ent[gi])
			);
		end
	end

	// Captured transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= func_t'(func);
			req_q <= req_size;
			pin_q <= ptr_in;
		end
	end

	// Result of the finished transaction and the new heap state.
	always_comb begin
		r_ptr    = 16'd0;
		r_status = ST_OK;
		r_used   = used_q;
		r_total  = total_q;
		r_count  = count_q;
		unique case (op_q)
			FN_ALLOC: begin
				if (req_q == 16'd0) begin
					r_status = ST_ZERO;
				end else if (res.found) begin
					r_ptr   = res.ptr;
					r_used  = used_q + res.delta;
					r_count = res.count;
				end else begin
					r_status = ST_NOFIT;
				end
			end
			FN_FREE: begin
				if (pin_q == 16'd0) begin
					r_status = ST_NULL;
				end else if (res.found && !res.bad) begin
					r_used  = used_q - res.delta;
					r_count = res.count;
				end else begin
					r_status = ST_BADPTR;
				end
			end
			FN_FORMAT: begin
				r_used  = 17'd0;
				r_total = fmt_total;
				r_count = CNT_W'(1);
			end
			FN_NONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			used_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				count_q     <= r_count;
				used_q      <= r_used;
				total_q     <= r_total;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (finish) begin
			ptr_out_q   <= r_ptr;
			status_q    <= r_status;
			used_out_q  <= r_used;
			total_out_q <= r_total;
		end
	end

	assign out_valid   = out_valid_q;
	assign ptr_out     = ptr_out_q;
	assign status      = status_q;
	assign used_bytes  = used_out_q;
	assign total_bytes = total_out_q;

endmodule
`default_nettype wire
